// File: hw/rtl/icf_pkg.sv
// ----------------------------------------------------------------------------
// icf_pkg
// Shared types, constants and the arctangent table of the attitude filter.
// ----------------------------------------------------------------------------
package icf_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ALPHA  = 2'd0;
    localparam logic [1:0] CFG_PERIOD = 2'd1;
    localparam logic [1:0] CFG_RANGE  = 2'd2;

    localparam logic [15:0] ALPHA_RESET  = 16'd64225;
    localparam logic [15:0] PERIOD_RESET = 16'd10000;
    localparam logic [2:0]  RANGE_RESET  = 3'd4;

    // Accelerometer values enter the CORDIC scaled by 2^14.
    localparam int ACC_PRESHIFT = 14;
    // Square root of a 60-bit operand: one result bit per step.
    localparam int SQRT_STEPS   = 30;
    localparam int SQRT_OP_W    = 2 * SQRT_STEPS;
    // CORDIC x/y width; covers the gain of a 2^29.5 input vector.
    localparam int CORDIC_W     = 33;
    localparam int TABLE_LEN    = 24;
    localparam int TABLE_IDX_W  = 5;
    // Step counter of the controller, wide enough for the longest phase.
    localparam int CNT_W        = 5;

    // Gyro step denominator: 2048 LSB/dps times 10^6 us/s.
    localparam logic [31:0] GYRO_DEN = 32'd2048000000;

    typedef logic [31:0] atan_tbl_t [TABLE_LEN];

    // atan(2^-i) in degrees, Q24.
    localparam atan_tbl_t ATAN_Q24 = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    // Table entry rounded half up to the given number of fraction bits.
    function automatic logic [31:0] atan_step(input logic [TABLE_IDX_W-1:0] idx,
                                              input int frac_bits);
        logic [31:0] raw;
        raw = ATAN_Q24[idx];
        return (raw + (32'd1 << (23 - frac_bits))) >> (24 - frac_bits);
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             prep;
        logic             run;
        logic             pinit;
        logic             pitch;
        logic             mul;
        logic             sum;
        logic             commit;
        logic [CNT_W-1:0] cnt;
    } icf_cmd_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PREP  = 8'b0000_0010,
        S_RUN   = 8'b0000_0100,
        S_PINIT = 8'b0000_1000,
        S_PITCH = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_SUM   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } icf_state_t;

endpackage

// File: hw/rtl/icf_ctrl.sv
// ----------------------------------------------------------------------------
// icf_ctrl
// Sequencer of the attitude filter: steps the datapath through its phases
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module icf_ctrl
    import icf_pkg::*;
#(
    parameter int ITER    = 16,
    parameter int RUN_LEN = 30
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output icf_cmd_t cmd
);

    icf_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.cnt        = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.run  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RUN_LEN - 1))
                begin
                    state_next = S_PINIT;
                end
            end
            S_PINIT:
            begin
                cmd.pinit  = 1'b1;
                cnt_next   = '0;
                state_next = S_PITCH;
            end
            S_PITCH:
            begin
                cmd.pitch = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ITER - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // The result register is free once the previous transaction leaves.
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/icf_datapath.sv
// ----------------------------------------------------------------------------
// icf_datapath
// Square root, shared CORDIC, three gyro dividers, blend and angle state.
// ----------------------------------------------------------------------------
module icf_datapath
    import icf_pkg::*;
#(
    parameter int ITER = 16,
    parameter int F    = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  icf_cmd_t           cmd,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic signed [15:0] rate_z,
    output logic signed [31:0] roll_angle,
    output logic signed [31:0] pitch_angle,
    output logic signed [31:0] yaw_angle
);

    localparam int ZW = F + 10;
    localparam int NW = 39 + F;
    localparam int QW = 9 + F;
    localparam int PW = 34;
    localparam int SW = 56;
    localparam int XW = CORDIC_W;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(90) <<< F;

    // Gyro division: GYRO_DEN is 2^17 * 15625, so the rounded numerator is
    // shifted down by 17 and divided by 15625 through a reciprocal multiply.
    localparam int XN = NW - 17;
    localparam int NC = (XN + 15) / 16;
    localparam int XP = 16 * NC;
    localparam int MW = XN + 1;
    localparam int RW = 2 * XN + 1;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << (XN + 14)) / 64'd15625) + 64'd1);

    // Configuration.
    logic [15:0] alpha_reg, period_reg;
    logic [2:0]  range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= ALPHA_RESET;
            period_reg <= PERIOD_RESET;
            range_reg  <= RANGE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ALPHA:  alpha_reg  <= cfg_data;
                CFG_PERIOD: period_reg <= cfg_data;
                CFG_RANGE:  range_reg  <= cfg_data[2:0];
                default:    ;
            endcase
        end
    end

    // Sample registers.
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [15:0] rate_reg [3];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg      <= accel_x;
            ay_reg      <= accel_y;
            az_reg      <= accel_z;
            rate_reg[0] <= rate_x;
            rate_reg[1] <= rate_y;
            rate_reg[2] <= rate_z;
        end
    end

    // Square root of (ay^2 + az^2) * 2^28, two operand bits per step.
    logic [SQRT_OP_W-1:0] sq_op_reg;
    logic [SQRT_STEPS+1:0] sq_rem_reg;
    logic [SQRT_STEPS-1:0] sq_root_reg;
    logic [31:0]           mag2;
    logic [SQRT_STEPS+1:0] sq_try_rem, sq_trial;

    assign mag2       = 32'($signed(ay_reg) * $signed(ay_reg))
                      + 32'($signed(az_reg) * $signed(az_reg));
    assign sq_try_rem = {sq_rem_reg[SQRT_STEPS-1:0], sq_op_reg[SQRT_OP_W-1 -: 2]};
    assign sq_trial   = {sq_root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            sq_op_reg   <= SQRT_OP_W'(mag2) << (2 * ACC_PRESHIFT);
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (cmd.run && (cmd.cnt < CNT_W'(SQRT_STEPS)))
        begin
            sq_op_reg <= sq_op_reg << 2;
            if (sq_try_rem >= sq_trial)
            begin
                sq_rem_reg  <= sq_try_rem - sq_trial;
                sq_root_reg <= {sq_root_reg[SQRT_STEPS-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= sq_try_rem;
                sq_root_reg <= {sq_root_reg[SQRT_STEPS-2:0], 1'b0};
            end
        end
    end

    // Gyro step per axis: round(|rate| * dt * 2^(range+F) / GYRO_DEN).
    // The product with the reciprocal is built one 16-bit digit of the
    // dividend per cycle, most significant digit first.
    logic [XP-1:0] dv_x_reg   [3];
    logic [RW-1:0] dv_acc_reg [3];
    logic [QW-1:0] dv_q       [3];
    logic          dv_neg_reg [3];
    logic [15:0]   rate_mag   [3];
    logic [NW-1:0] dv_num     [3];
    logic [5:0]    gyro_sh;

    assign gyro_sh = 6'(range_reg) + 6'(F);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rate_mag[k] = rate_reg[k][15] ? 16'(-rate_reg[k]) : 16'(rate_reg[k]);
            dv_num[k]   = (NW'(32'(rate_mag[k]) * 32'(period_reg)) << gyro_sh)
                        + NW'(GYRO_DEN >> 1);
            dv_q[k]     = dv_acc_reg[k][XN+14 +: QW];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (cmd.prep)
            begin
                dv_x_reg[k]   <= XP'(dv_num[k] >> 17);
                dv_acc_reg[k] <= '0;
                dv_neg_reg[k] <= rate_reg[k][15];
            end
            else if (cmd.run && (cmd.cnt < CNT_W'(NC)))
            begin
                dv_x_reg[k]   <= dv_x_reg[k] << 16;
                dv_acc_reg[k] <= (dv_acc_reg[k] << 16)
                               + RW'(dv_x_reg[k][XP-1 -: 16] * RECIP);
            end
        end
    end

    // Shared CORDIC in vectoring mode: roll during the run phase, then pitch.
    logic signed [XW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic                 czero_reg;
    logic signed [XW-1:0] init_x, init_y, rot_x, rot_y, dx, dy;
    logic signed [ZW-1:0] rot_z, step;
    logic signed [ZW-1:0] acc_roll_reg, cordic_angle;
    logic                 cstep;

    always_comb
    begin
        if (cmd.pinit)
        begin
            init_x = XW'(sq_root_reg);
            init_y = -(XW'(ax_reg) <<< ACC_PRESHIFT);
        end
        else
        begin
            init_x = XW'(az_reg) <<< ACC_PRESHIFT;
            init_y = XW'(ay_reg) <<< ACC_PRESHIFT;
        end
        rot_x = init_x;
        rot_y = init_y;
        rot_z = '0;
        // A vector in the left half plane is first turned by a quarter turn.
        if (init_x < 0)
        begin
            if (init_y >= 0)
            begin
                rot_x = init_y;
                rot_y = -init_x;
                rot_z = QUARTER;
            end
            else
            begin
                rot_x = -init_y;
                rot_y = init_x;
                rot_z = -QUARTER;
            end
        end
    end

    assign dx    = cy_reg >>> cmd.cnt;
    assign dy    = cx_reg >>> cmd.cnt;
    assign step  = ZW'(atan_step(cmd.cnt[TABLE_IDX_W-1:0], F));
    assign cstep = (cmd.run || cmd.pitch) && (cmd.cnt < CNT_W'(ITER));
    assign cordic_angle = czero_reg ? '0 : cz_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.prep || cmd.pinit)
        begin
            cx_reg    <= rot_x;
            cy_reg    <= rot_y;
            cz_reg    <= rot_z;
            czero_reg <= (init_x == 0) && (init_y == 0);
        end
        else if (cstep)
        begin
            if (!cy_reg[XW-1])
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + step;
            end
            else
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - step;
            end
        end
        if (cmd.pinit)
        begin
            acc_roll_reg <= cordic_angle;
        end
    end

    // Blend and angle state.
    logic signed [31:0]   roll_mem_reg, pitch_mem_reg, yaw_mem_reg;
    logic signed [31:0]   roll_res_reg, pitch_res_reg, yaw_res_reg;
    logic signed [SW-1:0] pa_reg [2];
    logic signed [SW-1:0] pb_reg [2];
    logic signed [PW-1:0] delta  [3];
    logic signed [PW-1:0] pred   [2];
    logic signed [ZW-1:0] acc    [2];
    logic signed [17:0]   wa, wb;
    logic signed [SW-1:0] bsum   [2];
    logic signed [SW-1:0] bshift [2];
    logic signed [31:0]   bsat   [2];

    assign wa     = $signed({2'b00, alpha_reg});
    assign wb     = $signed(18'd65536 - {2'b00, alpha_reg});
    assign pred[0] = PW'(roll_mem_reg) + delta[0];
    assign pred[1] = PW'(pitch_mem_reg) + delta[1];
    assign acc[0]  = acc_roll_reg;
    assign acc[1]  = cordic_angle;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            delta[k] = dv_neg_reg[k] ? -PW'(dv_q[k]) : PW'(dv_q[k]);
        end
        for (int k = 0; k < 2; k++)
        begin
            bsum[k]   = pa_reg[k] + pb_reg[k] + SW'(32768);
            bshift[k] = bsum[k] >>> 16;
            if (bshift[k] > SW'(32'sh7fff_ffff))
            begin
                bsat[k] = 32'sh7fff_ffff;
            end
            else if (bshift[k] < -SW'(33'sh0_8000_0000))
            begin
                bsat[k] = 32'sh8000_0000;
            end
            else
            begin
                bsat[k] = 32'(bshift[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            for (int k = 0; k < 2; k++)
            begin
                pa_reg[k] <= SW'(wa * pred[k]);
                pb_reg[k] <= SW'(wb * acc[k]);
            end
        end
        if (cmd.sum)
        begin
            roll_res_reg  <= bsat[0];
            pitch_res_reg <= bsat[1];
            yaw_res_reg   <= yaw_mem_reg + 32'(delta[2]);
        end
        if (cmd.commit)
        begin
            roll_angle  <= roll_res_reg;
            pitch_angle <= pitch_res_reg;
            yaw_angle   <= yaw_res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_mem_reg  <= '0;
            pitch_mem_reg <= '0;
            yaw_mem_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            roll_mem_reg  <= roll_res_reg;
            pitch_mem_reg <= pitch_res_reg;
            yaw_mem_reg   <= yaw_res_reg;
        end
    end

endmodule

// File: hw/rtl/imu_attitude_complementary_filter_unit.sv
// ----------------------------------------------------------------------------
// imu_attitude_complementary_filter_unit
// Roll, pitch and yaw from raw six-axis IMU samples by complementary filter.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one raw sample (three accel and three gyro axes)
// per transaction with in_valid/in_stall; in_stall is high while a sample
// is being processed. The output channel returns one transaction per
// sample with roll, pitch and yaw in signed fixed-point degrees.
// A sample passes through the 30-step bit-serial square root, which runs
// beside the roll CORDIC and the gyro dividers, followed by the pitch
// CORDIC on the same unit, then the blend and the output register.
// The next sample is accepted in the cycle after the result is loaded;
// no new sample is taken while one is still in progress.
// If the receiver stalls, the result waits in the output register and the
// next sample still runs; its result is held back until the register frees.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// Reset clears the angle state and loads the default alpha, period and range.
// ----------------------------------------------------------------------------
module imu_attitude_complementary_filter_unit
    import icf_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic signed [15:0] rate_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] roll_angle,
    output logic signed [31:0] pitch_angle,
    output logic signed [31:0] yaw_angle
);

    // The gyro division takes one step per 16-bit digit of its dividend.
    localparam int DIV_STEPS = (37 + ANGLE_FRAC_BITS) / 16;
    localparam int RUN_A     = (SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS;
    localparam int RUN_LEN   = (RUN_A > CORDIC_ITERATIONS) ? RUN_A : CORDIC_ITERATIONS;

    icf_cmd_t cmd;

    icf_ctrl #(
        .ITER    (CORDIC_ITERATIONS),
        .RUN_LEN (RUN_LEN)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    icf_datapath #(
        .ITER (CORDIC_ITERATIONS),
        .F    (ANGLE_FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .rate_x      (rate_x),
        .rate_y      (rate_y),
        .rate_z      (rate_z),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle)
    );

endmodule

// File: hw/rtl/icf_checker.sv
// ----------------------------------------------------------------------------
// icf_checker
// Port-level checks of the attitude filter, bound to the top level.
// ----------------------------------------------------------------------------
module icf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] roll_angle,
    input logic [31:0] pitch_angle,
    input logic [31:0] yaw_angle
);

    // A result that is stalled stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(roll_angle)
            && $stable(pitch_angle) && $stable(yaw_angle))
        else $error("stalled result changed");

    // An accepted sample keeps the input side busy in the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not busy after a transaction");

    // A new result appears only at the end of work on a sample.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no sample in progress");

endmodule

bind imu_attitude_complementary_filter_unit icf_checker u_icf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle)
);

// File: verif/imu_attitude_complementary_filter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_attitude_complementary_filter_unit_test
// Drives raw IMU samples through the attitude filter and checks each result
// transaction against a bit-accurate attitude predictor, across several
// register settings and with random idling and output back-pressure.
// ----------------------------------------------------------------------------
module imu_attitude_complementary_filter_unit_test;
    import icf_pkg::*;

    localparam int ITERS = 16;
    localparam int FRAC  = 16;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
    } imu_sample_t;

    typedef struct packed {
        logic signed [31:0] roll;
        logic signed [31:0] pitch;
        logic signed [31:0] yaw;
    } attitude_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
    logic signed [15:0] rate_x = '0, rate_y = '0, rate_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] roll_angle, pitch_angle, yaw_angle;

    imu_attitude_complementary_filter_unit dut (.*);

    always #2 clk = ~clk;

    imu_sample_t pending_samples[$];
    attitude_t   expected_attitude[$];
    int          error_count = 0;
    bit          hold_output = 1'b0;

    // Predictor copy of registers and angle state.
    longint unsigned p_alpha, p_period, p_range;
    longint p_roll, p_pitch, p_yaw;

    function automatic longint asr(longint v, int s);
        return (v >= 0) ? (v >>> s) : (-((-(v + 1)) >>> s) - 1);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, t, dx, dy, stp;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 90 * (64'sd1 << FRAC);
            end else begin
                t = x; x = -y; y = t; z = -90 * (64'sd1 << FRAC);
            end
        end
        for (int i = 0; i < ITERS; i++) begin
            stp = (longint'(ATAN_Q24[i]) + (64'sd1 << (23 - FRAC))) >>> (24 - FRAC);
            dx = asr(y, i);
            dy = asr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += stp;
            end else begin
                x -= dx; y += dy; z -= stp;
            end
        end
        return z;
    endfunction

    function automatic longint rate_increment(longint raw);
        longint unsigned mag, num, q;
        mag = (raw < 0) ? -raw : raw;
        num = mag * p_period * (64'd1 << (p_range + FRAC));
        q = (num + 64'd1024000000) / 64'd2048000000;
        return (raw < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint fuse_angle(longint prev, longint delta, longint acc);
        longint pred, a, s;
        pred = prev + delta;
        a = p_alpha;
        s = asr(a * pred + (65536 - a) * acc + 32768, 16);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s;
    endfunction

    function automatic attitude_t predict_attitude(imu_sample_t s);
        longint ay, az, r, acc_r, acc_p;
        attitude_t o;
        ay = s.ay;
        az = s.az;
        r = int_sqrt(longint'(ay * ay + az * az) << 28);
        acc_r = vector_angle(ay <<< 14, az <<< 14);
        acc_p = vector_angle(-longint'(s.ax) <<< 14, r);
        p_roll = fuse_angle(p_roll, rate_increment(s.gx), acc_r);
        p_pitch = fuse_angle(p_pitch, rate_increment(s.gy), acc_p);
        p_yaw = longint'(int'(p_yaw + rate_increment(s.gz)));
        o.roll = p_roll[31:0];
        o.pitch = p_pitch[31:0];
        o.yaw = p_yaw[31:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t",
                 what, $signed(got), $signed(want), $realtime);
        error_count++;
    endtask

    // Driver: one sample per transaction, random gap before each.
    int gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_attitude.push_back(predict_attitude(pending_samples.pop_front()));
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            end
            if (!in_valid || !in_stall) begin
                if (pending_samples.size() > 0 && gap == 0) begin
                    in_valid <= 1'b1;
                    {accel_x, accel_y, accel_z, rate_x, rate_y, rate_z}
                        <= pending_samples[0];
                end else begin
                    in_valid <= 1'b0;
                    if (gap > 0) gap--;
                end
            end
        end
    end

    // Monitor: checks results and draws output stalls.
    int stall_left = 0;
    always @(posedge clk) begin
        attitude_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_attitude.size() == 0) begin
                    $display("unexpected result transaction at %0t", $realtime);
                    error_count++;
                end else begin
                    want = expected_attitude.pop_front();
                    if (roll_angle !== want.roll)
                        report_mismatch("roll", roll_angle, want.roll);
                    if (pitch_angle !== want.pitch)
                        report_mismatch("pitch", pitch_angle, want.pitch);
                    if (yaw_angle !== want.yaw)
                        report_mismatch("yaw", yaw_angle, want.yaw);
                end
                stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            end
            if (hold_output) out_stall <= 1'b1;
            else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else out_stall <= 1'b0;
        end
    end

    task automatic write_register(logic [1:0] idx, logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_ALPHA) p_alpha = value;
        else if (idx == CFG_PERIOD) p_period = value;
        else if (idx == CFG_RANGE) p_range = value[2:0];
    endtask

    task automatic wait_drained();
        while (pending_samples.size() > 0 || expected_attitude.size() > 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random(int n);
        imu_sample_t s;
        repeat (n) begin
            s = {pick_axis(), pick_axis(), pick_axis(),
                 pick_axis(), pick_axis(), pick_axis()};
            pending_samples.push_back(s);
        end
    endtask

    initial begin
        p_alpha = ALPHA_RESET;
        p_period = PERIOD_RESET;
        p_range = RANGE_RESET;
        p_roll = 0;
        p_pitch = 0;
        p_yaw = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero vector, negative x with zero y, extremes.
        pending_samples.push_back('0);
        pending_samples.push_back({16'sd0, 16'sd0, -16'sd1000, 48'd0});
        pending_samples.push_back({16'sd0, 16'sd0, 16'sh8000, 48'd0});
        pending_samples.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff,
                                   16'sh7fff, 16'sh7fff, 16'sh7fff});
        pending_samples.push_back({16'sh8000, 16'sh8000, 16'sh8000,
                                   16'sh8000, 16'sh8000, 16'sh8000});
        pending_samples.push_back({16'sh8000, 16'sd0, 16'sd0, 48'd0});
        pending_samples.push_back({16'sd0, -16'sd500, -16'sd500, 48'd0});
        pending_samples.push_back({16'sd0, 16'sd500, -16'sd500, 48'd0});
        wait_drained();

        // Saturation: full gyro trust, widest range, longest period.
        write_register(CFG_ALPHA, 16'hffff);
        write_register(CFG_PERIOD, 16'hffff);
        write_register(CFG_RANGE, 3'd7);
        repeat (8) pending_samples.push_back({48'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        repeat (8) pending_samples.push_back({48'd0, 16'sh8000, 16'sh8000, 16'sh8000});
        wait_drained();

        // Zero period, zero alpha and zero range, then an invalid register index.
        write_register(CFG_PERIOD, 16'd0);
        write_register(CFG_ALPHA, 16'd0);
        write_register(CFG_RANGE, 3'd0);
        write_register(2'd3, 16'hffff);
        queue_random(6);
        wait_drained();

        write_register(CFG_PERIOD, 16'd1);
        write_register(CFG_ALPHA, 16'd1);
        queue_random(150);
        wait_drained();

        // Back-pressure: hold the output while samples keep coming.
        write_register(CFG_ALPHA, ALPHA_RESET);
        write_register(CFG_PERIOD, PERIOD_RESET);
        write_register(CFG_RANGE, RANGE_RESET);
        hold_output = 1'b1;
        queue_random(200);
        repeat (400) @(posedge clk);
        hold_output = 1'b0;
        wait_drained();

        write_register(CFG_ALPHA, 16'($urandom));
        write_register(CFG_PERIOD, 16'($urandom_range(1, 65535)));
        write_register(CFG_RANGE, 3'($urandom));
        queue_random(250);
        wait_drained();

        if (error_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #8ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: imu_attitude_complementary_filter_unit.f
hw/rtl/icf_pkg.sv
hw/rtl/icf_ctrl.sv
hw/rtl/icf_datapath.sv
hw/rtl/imu_attitude_complementary_filter_unit.sv
hw/rtl/icf_checker.sv
verif/imu_attitude_complementary_filter_unit_test.sv
